FILE: rtl/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared constants, codes and control types of the first-fit pool allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

	// Default pool geometry.
	localparam int POOL_BYTES_DEF   = 4096;
	localparam int HEADER_BYTES_DEF = 16;

	// Operation codes of an input item.
	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_QUERY   = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	// Read address selects.
	localparam logic [2:0] RD_NONE  = 3'd0;
	localparam logic [2:0] RD_ZERO  = 3'd1;
	localparam logic [2:0] RD_DNEXT = 3'd2;
	localparam logic [2:0] RD_HDR   = 3'd3;
	localparam logic [2:0] RD_PREV  = 3'd4;
	localparam logic [2:0] RD_NEXT  = 3'd5;

	// Register load selects.
	localparam logic [2:0] LD_NONE  = 3'd0;
	localparam logic [2:0] LD_INPUT = 3'd1;
	localparam logic [2:0] LD_WALK  = 3'd2;
	localparam logic [2:0] LD_H     = 3'd3;
	localparam logic [2:0] LD_P     = 3'd4;
	localparam logic [2:0] LD_N     = 3'd5;

	// Header write patterns.
	localparam logic [3:0] WR_NONE      = 4'd0;
	localparam logic [3:0] WR_SPLIT_HDR = 4'd1;
	localparam logic [3:0] WR_NOSPLIT   = 4'd2;
	localparam logic [3:0] WR_NEW       = 4'd3;
	localparam logic [3:0] WR_AFIX      = 4'd4;
	localparam logic [3:0] WR_RHDR      = 4'd5;
	localparam logic [3:0] WR_KILLN     = 4'd6;
	localparam logic [3:0] WR_RPREV     = 4'd7;
	localparam logic [3:0] WR_RFIX      = 4'd8;

	// Free counter updates.
	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_SUB  = 2'd1;
	localparam logic [1:0] CNT_ADD  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic [2:0] rd_sel;
		logic [2:0] ld;
		logic [3:0] wr;
		logic [1:0] cnt;
		logic       set_fail;
		logic       done;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] op;
		logic       fit;
		logic       d_hn;
		logic       walk_last;
		logic       rel_ok;
		logic       h_busy;
		logic       h_hp;
		logic       h_hn;
		logic       split;
		logic       jp;
		logic       jn;
		logic       hn_new;
		logic       out_busy;
	} sts_t;

endpackage

FILE: rtl/ffpa_in_if.sv
// ----------------------------------------------------------------------------
// ffpa_in_if
// Request channel: operation, allocate size and release address.
// ----------------------------------------------------------------------------
interface ffpa_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [11:0] request_size;
	logic [11:0] release_address;

	modport source(output valid, output op, output request_size,
		output release_address, input ready);
	modport sink(input valid, input op, input request_size,
		input release_address, output ready);
endinterface

FILE: rtl/ffpa_out_if.sv
// ----------------------------------------------------------------------------
// ffpa_out_if
// Result channel: status, granted address and free byte figures.
// ----------------------------------------------------------------------------
interface ffpa_out_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [11:0] payload_address;
	logic [12:0] running_free;
	logic [12:0] counted_free;

	modport source(output valid, output status, output payload_address,
		output running_free, output counted_free, input ready);
	modport sink(input valid, input status, input payload_address,
		input running_free, input counted_free, output ready);
endinterface

FILE: rtl/first_fit_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_unit
// First-fit pool allocator with splitting and coalescing of free chunks.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns one result for each.
// Allocate and query walk the chunk chain from offset 0 through a single
// memory read port, one header per cycle. A query then loads the result
// register; an allocate writes the header of the fitting chunk and, on a
// split, the header of the new free chunk and, if a chunk follows, its
// backward link. A release reads the header of the chunk and of its two
// neighbors where they exist, and then issues up to four header writes.
// A new request is taken while the previous result still waits on the
// result channel. No clearing pass runs after reset; the header at offset 0
// starts as one free chunk.
module first_fit_pool_allocator_unit
	import ffpa_pkg::*;
#(
	parameter int POOL_BYTES   = POOL_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	ffpa_in_if.sink   request,
	ffpa_out_if.source result
);

	cmd_t cmd;
	sts_t sts;
	logic ctrl_ready;

	ffpa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(request.valid),
		.in_ready(ctrl_ready),
		.cmd     (cmd),
		.sts     (sts)
	);

	ffpa_datapath #(
		.POOL_BYTES  (POOL_BYTES),
		.HEADER_BYTES(HEADER_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.op             (request.op),
		.request_size   (request.request_size),
		.release_address(request.release_address),
		.result         (result)
	);

	assign request.ready = ctrl_ready;

	// A transfer in starts work, so no second one follows at once.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(request.valid && request.ready) |=> !request.ready)
		else $error("request taken while an item is in work");

	// The header memory is never read and written in the same cycle.
	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr != WR_NONE) |-> (cmd.rd_sel == RD_NONE))
		else $error("header read and write in one cycle");

	// A failed allocate grants no address.
	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status) |-> (result.payload_address == '0))
		else $error("address given with a no-fit status");

endmodule

FILE: rtl/ffpa_hdr_store.sv
// ----------------------------------------------------------------------------
// ffpa_hdr_store
// Chunk header memory, split into a state group (live, free, size), a
// backward link group and a forward link group that are written separately.
// ----------------------------------------------------------------------------
module ffpa_hdr_store
	import ffpa_pkg::*;
#(
	parameter int POOL_BYTES   = POOL_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	localparam int AW = $clog2(POOL_BYTES),
	localparam int SW = AW + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] wr_addr,
	input  logic          we_a,
	input  logic          we_p,
	input  logic          we_n,
	input  logic          wa_live,
	input  logic          wa_free,
	input  logic [SW-1:0] wa_size,
	input  logic          wp_hp,
	input  logic [AW-1:0] wp_prev,
	input  logic          wn_hn,
	input  logic [AW-1:0] wn_next,
	output logic          rd_live,
	output logic          rd_free,
	output logic [SW-1:0] rd_size,
	output logic          rd_hp,
	output logic [AW-1:0] rd_prev,
	output logic          rd_hn,
	output logic [AW-1:0] rd_next
);

	localparam logic [SW-1:0] INIT_SIZE = SW'(POOL_BYTES - HEADER_BYTES);

	logic [SW+1:0] mem_a [POOL_BYTES];
	logic [AW:0]   mem_p [POOL_BYTES];
	logic [AW:0]   mem_n [POOL_BYTES];
	logic [SW+1:0] a_q;
	logic [AW:0]   p_q;
	logic [AW:0]   n_q;
	logic [AW-1:0] rd_addr_q;
	logic          v0a_q, v0p_q, v0n_q;
	logic          at0;

	// Memory write ports.
	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[wr_addr] <= {wa_live, wa_free, wa_size};
		end
		if (we_p) begin
			mem_p[wr_addr] <= {wp_hp, wp_prev};
		end
		if (we_n) begin
			mem_n[wr_addr] <= {wn_hn, wn_next};
		end
	end

	// Registered read, all groups at one address.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			a_q <= mem_a[rd_addr];
			p_q <= mem_p[rd_addr];
			n_q <= mem_n[rd_addr];
		end
	end

	// Read address and the written marks of the first entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
			v0a_q     <= 1'b0;
			v0p_q     <= 1'b0;
			v0n_q     <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_addr_q <= rd_addr;
			end
			if (wr_addr == '0) begin
				if (we_a) v0a_q <= 1'b1;
				if (we_p) v0p_q <= 1'b1;
				if (we_n) v0n_q <= 1'b1;
			end
		end
	end

	// The first entry reads as the initial free chunk until it is written.
	assign at0 = (rd_addr_q == '0);

	always_comb begin
		{rd_live, rd_free, rd_size} = (at0 && !v0a_q) ? {1'b1, 1'b1, INIT_SIZE} : a_q;
		{rd_hp, rd_prev}            = (at0 && !v0p_q) ? '0 : p_q;
		{rd_hn, rd_next}            = (at0 && !v0n_q) ? '0 : n_q;
	end

endmodule

FILE: rtl/ffpa_datapath.sv
// ----------------------------------------------------------------------------
// ffpa_datapath
// Operand registers, chain walk, split and merge arithmetic, free counter,
// header memory and the result register.
// ----------------------------------------------------------------------------
module ffpa_datapath
	import ffpa_pkg::*;
#(
	parameter int POOL_BYTES   = POOL_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [1:0]  op,
	input  logic [11:0] request_size,
	input  logic [11:0] release_address,
	ffpa_out_if.source  result
);

	localparam int AW = $clog2(POOL_BYTES);
	localparam int SW = AW + 1;
	localparam int XW = ((AW > 12) ? AW : 12) + 3;
	localparam logic [XW-1:0] HB   = XW'(HEADER_BYTES);
	localparam logic [XW-1:0] POOL = XW'(POOL_BYTES);
	localparam logic [SW-1:0] STEP_LAST = SW'(POOL_BYTES - 1);

	// Operand registers.
	logic [1:0]    op_q;
	logic [11:0]   req_q;
	logic [11:0]   rel_q;
	logic [XW-1:0] need_q;
	logic [AW-1:0] cur_q;
	logic [AW-1:0] hdr_q;
	logic [SW-1:0] steps_q;
	logic [12:0]   sum_q;
	logic          fail_q;
	logic [SW-1:0] cnt_q;
	// Chunk under work, its previous and its next neighbor.
	logic          h_live, h_free, h_hp, h_hn;
	logic [SW-1:0] h_size;
	logic [AW-1:0] h_prev, h_next;
	logic          p_live, p_free;
	logic [SW-1:0] p_size;
	logic          n_free, n_hn;
	logic [SW-1:0] n_size;
	logic [AW-1:0] n_next;
	// Result register.
	logic          out_valid_q;

	// Memory signals.
	logic          rd_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          we_a, we_p, we_n;
	logic          wa_live, wa_free, wp_hp, wn_hn;
	logic [SW-1:0] wa_size;
	logic [AW-1:0] wp_prev, wn_next;
	logic          rd_live, rd_free, rd_hp, rd_hn;
	logic [SW-1:0] rd_size;
	logic [AW-1:0] rd_prev, rd_next;

	// Derived values.
	logic [XW-1:0] rest, nh, rel_hdr;
	logic          jp, jn, hn_new;
	logic [AW-1:0] next_new;
	logic [SW-1:0] hsize_new, psize_new;
	logic [XW:0]   cnt_sum;

	ffpa_hdr_store #(
		.POOL_BYTES  (POOL_BYTES),
		.HEADER_BYTES(HEADER_BYTES)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.we_a   (we_a),
		.we_p   (we_p),
		.we_n   (we_n),
		.wa_live(wa_live),
		.wa_free(wa_free),
		.wa_size(wa_size),
		.wp_hp  (wp_hp),
		.wp_prev(wp_prev),
		.wn_hn  (wn_hn),
		.wn_next(wn_next),
		.rd_live(rd_live),
		.rd_free(rd_free),
		.rd_size(rd_size),
		.rd_hp  (rd_hp),
		.rd_prev(rd_prev),
		.rd_hn  (rd_hn),
		.rd_next(rd_next)
	);

	// Split and merge arithmetic.
	assign rest      = XW'(h_size) - need_q;
	assign nh        = XW'(hdr_q) + need_q;
	assign rel_hdr   = XW'(rel_q) - HB;
	assign jp        = h_hp && p_free;
	assign jn        = h_hn && n_free;
	assign hn_new    = jn ? n_hn : h_hn;
	assign next_new  = jn ? n_next : h_next;
	assign hsize_new = jn ? SW'(XW'(h_size) + XW'(n_size) + HB) : h_size;
	assign psize_new = SW'(XW'(p_size) + XW'(hsize_new) + HB);
	assign cnt_sum   = (XW+1)'(cnt_q) + (XW+1)'(h_size) + (XW+1)'(HB);

	// Status toward the controller.
	always_comb begin
		sts.op        = op_q;
		sts.fit       = rd_live && rd_free && (XW'(rd_size) >= need_q);
		sts.d_hn      = rd_hn;
		sts.walk_last = (steps_q == STEP_LAST);
		sts.rel_ok    = (XW'(rel_q) >= HB) && (rel_hdr < POOL);
		sts.h_busy    = h_live && !h_free;
		sts.h_hp      = h_hp;
		sts.h_hn      = h_hn;
		sts.split     = (rest > HB) && (nh < POOL);
		sts.jp        = jp;
		sts.jn        = jn;
		sts.hn_new    = hn_new;
		sts.out_busy  = out_valid_q && !result.ready;
	end

	// Read address select.
	always_comb begin
		rd_en   = 1'b1;
		rd_addr = '0;
		case (cmd.rd_sel)
			RD_ZERO:  rd_addr = '0;
			RD_DNEXT: rd_addr = rd_next;
			RD_HDR:   rd_addr = AW'(rel_hdr);
			RD_PREV:  rd_addr = h_prev;
			RD_NEXT:  rd_addr = h_next;
			default:  rd_en = 1'b0;
		endcase
	end

	// Header write patterns.
	always_comb begin
		wr_addr = hdr_q;
		we_a    = 1'b0;
		we_p    = 1'b0;
		we_n    = 1'b0;
		wa_live = 1'b1;
		wa_free = 1'b0;
		wa_size = h_size;
		wp_hp   = 1'b1;
		wp_prev = hdr_q;
		wn_hn   = 1'b1;
		wn_next = AW'(nh);
		case (cmd.wr)
			WR_SPLIT_HDR: begin
				we_a    = 1'b1;
				we_n    = 1'b1;
				wa_size = SW'(req_q);
			end
			WR_NOSPLIT: begin
				we_a = 1'b1;
			end
			WR_NEW: begin
				wr_addr = AW'(nh);
				we_a    = 1'b1;
				we_p    = 1'b1;
				we_n    = 1'b1;
				wa_free = 1'b1;
				wa_size = SW'(rest);
				wn_hn   = h_hn;
				wn_next = h_next;
			end
			WR_AFIX: begin
				wr_addr = h_next;
				we_p    = 1'b1;
				wp_prev = AW'(nh);
			end
			WR_RHDR: begin
				we_a    = 1'b1;
				we_n    = jn;
				wa_live = !jp;
				wa_free = 1'b1;
				wa_size = hsize_new;
				wn_hn   = n_hn;
				wn_next = n_next;
			end
			WR_KILLN: begin
				wr_addr = h_next;
				we_a    = 1'b1;
				wa_live = 1'b0;
				wa_free = n_free;
				wa_size = n_size;
			end
			WR_RPREV: begin
				wr_addr = h_prev;
				we_a    = 1'b1;
				we_n    = 1'b1;
				wa_live = p_live;
				wa_free = p_free;
				wa_size = psize_new;
				wn_hn   = hn_new;
				wn_next = next_new;
			end
			WR_RFIX: begin
				wr_addr = next_new;
				we_p    = 1'b1;
				wp_prev = jp ? h_prev : hdr_q;
			end
			default: begin
				we_a = 1'b0;
			end
		endcase
	end

	// Operand and neighbor registers.
	always_ff @(posedge clk) begin
		case (cmd.ld)
			LD_INPUT: begin
				op_q    <= op;
				req_q   <= request_size;
				rel_q   <= release_address;
				need_q  <= XW'(request_size) + HB;
				cur_q   <= '0;
				hdr_q   <= AW'(XW'(release_address) - HB);
				steps_q <= '0;
				sum_q   <= '0;
			end
			LD_WALK: begin
				hdr_q   <= cur_q;
				cur_q   <= rd_next;
				steps_q <= steps_q + 1'b1;
				sum_q   <= (rd_live && rd_free) ? sum_q + 13'(rd_size) : sum_q;
				{h_live, h_free, h_size} <= {rd_live, rd_free, rd_size};
				{h_hp, h_prev, h_hn, h_next} <= {rd_hp, rd_prev, rd_hn, rd_next};
			end
			LD_H: begin
				{h_live, h_free, h_size} <= {rd_live, rd_free, rd_size};
				{h_hp, h_prev, h_hn, h_next} <= {rd_hp, rd_prev, rd_hn, rd_next};
			end
			LD_P: begin
				{p_live, p_free, p_size} <= {rd_live, rd_free, rd_size};
			end
			LD_N: begin
				{n_free, n_size, n_hn, n_next} <= {rd_free, rd_size, rd_hn, rd_next};
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	// Free counter and failure mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= SW'(POOL_BYTES - HEADER_BYTES);
			fail_q <= 1'b0;
		end else begin
			if (cmd.ld == LD_INPUT) begin
				fail_q <= 1'b0;
			end else if (cmd.set_fail) begin
				fail_q <= 1'b1;
			end
			case (cmd.cnt)
				CNT_SUB: cnt_q <= (need_q > XW'(cnt_q)) ? '0 : SW'(XW'(cnt_q) - need_q);
				CNT_ADD: cnt_q <= (cnt_sum > (XW+1)'(POOL)) ? SW'(POOL) : SW'(cnt_sum);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Result register; it holds until the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.done) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.done) begin
			result.status          <= fail_q;
			result.payload_address <= (op_q == OP_ALLOC && !fail_q) ?
				12'(XW'(hdr_q) + HB) : '0;
			result.running_free    <= 13'(cnt_q);
			result.counted_free    <= (op_q == OP_QUERY) ? sum_q : '0;
		end
	end

	assign result.valid = out_valid_q;

endmodule

FILE: rtl/ffpa_ctrl.sv
// ----------------------------------------------------------------------------
// ffpa_ctrl
// Sequencer of the allocator: walks the chain or reads a released chunk and
// its neighbors, then issues the split or merge header writes one per cycle.
// ----------------------------------------------------------------------------
module ffpa_ctrl
	import ffpa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_WALK = 4'd2;
	localparam logic [3:0] S_AFIT = 4'd3;
	localparam logic [3:0] S_ANEW = 4'd4;
	localparam logic [3:0] S_AFIX = 4'd5;
	localparam logic [3:0] S_RH   = 4'd6;
	localparam logic [3:0] S_RCK  = 4'd7;
	localparam logic [3:0] S_RP   = 4'd8;
	localparam logic [3:0] S_RN   = 4'd9;
	localparam logic [3:0] S_RW1  = 4'd10;
	localparam logic [3:0] S_RW2  = 4'd11;
	localparam logic [3:0] S_RW3  = 4'd12;
	localparam logic [3:0] S_RW4  = 4'd13;
	localparam logic [3:0] S_DONE = 4'd14;

	logic [3:0] state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld    = LD_INPUT;
					state_nxt = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.op)
					OP_ALLOC, OP_QUERY: begin
						cmd.rd_sel = RD_ZERO;
						state_nxt  = S_WALK;
					end
					OP_RELEASE: begin
						if (sts.rel_ok) begin
							cmd.rd_sel = RD_HDR;
							state_nxt  = S_RH;
						end else begin
							state_nxt = S_DONE;
						end
					end
					default: state_nxt = S_DONE;
				endcase
			end
			// One header per cycle; the next read follows the forward link.
			S_WALK: begin
				cmd.ld = LD_WALK;
				if (sts.op == OP_ALLOC && sts.fit) begin
					state_nxt = S_AFIT;
				end else if (!sts.d_hn || sts.walk_last) begin
					cmd.set_fail = (sts.op == OP_ALLOC);
					state_nxt    = S_DONE;
				end else begin
					cmd.rd_sel = RD_DNEXT;
				end
			end
			S_AFIT: begin
				cmd.cnt = CNT_SUB;
				if (sts.split) begin
					cmd.wr    = WR_SPLIT_HDR;
					state_nxt = S_ANEW;
				end else begin
					cmd.wr    = WR_NOSPLIT;
					state_nxt = S_DONE;
				end
			end
			S_ANEW: begin
				cmd.wr    = WR_NEW;
				state_nxt = sts.h_hn ? S_AFIX : S_DONE;
			end
			S_AFIX: begin
				cmd.wr    = WR_AFIX;
				state_nxt = S_DONE;
			end
			S_RH: begin
				cmd.ld    = LD_H;
				state_nxt = S_RCK;
			end
			// Release of a chunk in use; fetch the neighbors that exist.
			S_RCK: begin
				if (!sts.h_busy) begin
					state_nxt = S_DONE;
				end else begin
					cmd.cnt = CNT_ADD;
					if (sts.h_hp) begin
						cmd.rd_sel = RD_PREV;
						state_nxt  = S_RP;
					end else if (sts.h_hn) begin
						cmd.rd_sel = RD_NEXT;
						state_nxt  = S_RN;
					end else begin
						state_nxt = S_RW1;
					end
				end
			end
			S_RP: begin
				cmd.ld = LD_P;
				if (sts.h_hn) begin
					cmd.rd_sel = RD_NEXT;
					state_nxt  = S_RN;
				end else begin
					state_nxt = S_RW1;
				end
			end
			S_RN: begin
				cmd.ld    = LD_N;
				state_nxt = S_RW1;
			end
			S_RW1: begin
				cmd.wr    = WR_RHDR;
				state_nxt = S_RW2;
			end
			S_RW2: begin
				if (sts.jn) cmd.wr = WR_KILLN;
				state_nxt = S_RW3;
			end
			S_RW3: begin
				if (sts.jp) cmd.wr = WR_RPREV;
				state_nxt = S_RW4;
			end
			S_RW4: begin
				if ((sts.jn || sts.jp) && sts.hn_new) cmd.wr = WR_RFIX;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.done  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

endmodule
